### hdl/skht_pkg.sv
// Shared types and codes of the session key hash table.
package skht_pkg;

  // Stored key layout: dest, tunnel, ext tunnel address, sender, instance
  localparam int KEY_W = 128;

  // Request function codes
  localparam logic [2:0] FN_FIND     = 3'd0;
  localparam logic [2:0] FN_CREATE   = 3'd1;
  localparam logic [2:0] FN_DELETE   = 3'd2;
  localparam logic [2:0] FN_FIND_IDS = 3'd3;
  localparam logic [2:0] FN_CLEAR    = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Bucket head write operations
  localparam logic [1:0] HW_NONE = 2'd0;
  localparam logic [1:0] HW_CLR  = 2'd1;
  localparam logic [1:0] HW_NEW  = 2'd2;
  localparam logic [1:0] HW_NEXT = 2'd3;

  // Result handle sources
  localparam logic [1:0] RS_NONE = 2'd0;
  localparam logic [1:0] RS_CUR  = 2'd1;
  localparam logic [1:0] RS_CNT  = 2'd2;

  typedef struct packed {
    logic       load;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       hash_clr;
    logic       hash_step;
    logic       head_rd;
    logic       head_rd_scan;
    logic [1:0] head_wr;
    logic       cur_ld_head;
    logic       cur_ld_next;
    logic       prev_clr;
    logic       slot_rd;
    logic       slot_rd_hdl;
    logic       key_from_slot;
    logic       slot_wr_new;
    logic       next_wr_prev;
    logic       live_free;
    logic       live_clr_all;
    logic       resp_ld;
    logic [1:0] resp_status;
    logic [1:0] res_sel;
  } skht_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       hash_last;
    logic       bkt_last;
    logic       ent_last;
    logic       cur_valid;
    logic       prev_valid;
    logic       key_hit;
    logic       id_hit;
    logic       cur_is_hdl;
    logic       hdl_ok;
    logic       cnt_live;
  } skht_sts_t;

endpackage

### hdl/skht_dp.sv
// Datapath: key registers, hash unit, chain memories, result register.
module skht_dp import skht_pkg::*; #(
  parameter int BUCKETS = 1024,
  parameter int ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_dest_address,
  input  logic [15:0] in_tunnel_number,
  input  logic [31:0] in_ext_tunnel_address,
  input  logic [31:0] in_sender_address,
  input  logic [15:0] in_path_instance,
  input  logic [7:0]  in_entry_handle,
  input  skht_cmd_t   cmd,
  output skht_sts_t   sts,
  output logic [1:0]  out_status,
  output logic [7:0]  out_result_handle,
  output logic [9:0]  out_bucket_index
);

  localparam int BW    = $clog2(BUCKETS);
  localparam int IW    = $clog2(ENTRIES);
  localparam int LW    = IW + 1;
  localparam int CMAX0 = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
  localparam int CMAX  = (CMAX0 > 32) ? CMAX0 : 32;
  localparam int CW    = $clog2(CMAX) + 1;

  logic [2:0]       func_r;
  logic [KEY_W-1:0] key_r;
  logic [7:0]       handle_r;
  logic [CW-1:0]    cnt_r;
  logic [31:0]      hash_r;
  logic [LW-1:0]    cur_r;
  logic [IW-1:0]    prev_r;
  logic             prev_valid_r;
  logic [ENTRIES-1:0] live_r;
  logic [LW-1:0]    head_q;
  logic [KEY_W-1:0] key_q;
  logic [LW-1:0]    next_q;
  logic [1:0]       out_status_r;
  logic [7:0]       out_handle_r;
  logic [9:0]       out_bucket_r;

  logic [LW-1:0]    head_mem [BUCKETS];
  logic [KEY_W-1:0] key_mem  [ENTRIES];
  logic [LW-1:0]    next_mem [ENTRIES];

  logic [31:0]   hfield;
  logic [31:0]   hash_nxt;
  logic [BW-1:0] bucket;
  logic [IW-1:0] hsl;
  logic [IW-1:0] cnt_slot;
  logic [BW-1:0] head_waddr;
  logic [LW-1:0] head_wdata;
  logic [BW-1:0] head_raddr;
  logic [IW-1:0] slot_raddr;

  assign hsl      = IW'(handle_r);
  assign cnt_slot = cnt_r[IW-1:0];

  // Bucket is the hash modulo BUCKETS, a power of two: keep the low bits
  assign bucket = hash_r[BW-1:0];

  // Pick the key field for this hash step
  always_comb begin
    case (cnt_r[2:0])
      3'd0:    hfield = key_r[127:96];
      3'd1:    hfield = {16'b0, key_r[95:80]};
      3'd2:    hfield = key_r[79:48];
      3'd3:    hfield = key_r[47:16];
      default: hfield = {16'b0, key_r[15:0]};
    endcase
  end

  // Multiply by 31 as shift and subtract, then add the field
  assign hash_nxt = (hash_r << 5) - hash_r + hfield;

  // Capture request, advance counter and hash
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_func;
      key_r    <= {in_dest_address, in_tunnel_number, in_ext_tunnel_address,
                   in_sender_address, in_path_instance};
      handle_r <= in_entry_handle;
    end else if (cmd.key_from_slot) begin
      key_r <= key_q;
    end
    if (!rst_n || cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + CW'(1);
    end
    if (cmd.hash_clr) begin
      hash_r <= '0;
    end else if (cmd.hash_step) begin
      hash_r <= hash_nxt;
    end
  end

  // Walk cursor and trailing link
  always_ff @(posedge clk) begin
    if (cmd.cur_ld_head) begin
      cur_r <= head_q;
    end else if (cmd.cur_ld_next) begin
      cur_r <= next_q;
    end
    if (cmd.prev_clr) begin
      prev_valid_r <= 1'b0;
    end else if (cmd.cur_ld_next) begin
      prev_valid_r <= 1'b1;
      prev_r       <= cur_r[IW-1:0];
    end
  end

  // Bucket head memory
  always_comb begin
    head_waddr = bucket;
    head_wdata = next_q;
    case (cmd.head_wr)
      HW_CLR: begin
        head_waddr = cnt_r[BW-1:0];
        head_wdata = '0;
      end
      HW_NEW:  head_wdata = {1'b1, cnt_slot};
      default: head_wdata = next_q;
    endcase
  end

  assign head_raddr = cmd.head_rd_scan ? cnt_r[BW-1:0] : bucket;

  always_ff @(posedge clk) begin
    if (cmd.head_wr != HW_NONE) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (cmd.head_rd) begin
      head_q <= head_mem[head_raddr];
    end
  end

  // Slot key and link memories
  assign slot_raddr = cmd.slot_rd_hdl ? hsl : cur_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.slot_wr_new) begin
      key_mem[cnt_slot]  <= key_r;
      next_mem[cnt_slot] <= cur_r;
    end else if (cmd.next_wr_prev) begin
      next_mem[prev_r] <= next_q;
    end
    if (cmd.slot_rd) begin
      key_q  <= key_mem[slot_raddr];
      next_q <= next_mem[slot_raddr];
    end
  end

  // Live bits
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.live_clr_all) begin
      live_r <= '0;
    end else begin
      if (cmd.slot_wr_new) begin
        live_r[cnt_slot] <= 1'b1;
      end
      if (cmd.live_free) begin
        live_r[hsl] <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.resp_ld) begin
      out_status_r <= cmd.resp_status;
      case (cmd.res_sel)
        RS_CUR:  out_handle_r <= 8'(cur_r[IW-1:0]);
        RS_CNT:  out_handle_r <= 8'(cnt_slot);
        default: out_handle_r <= 8'd0;
      endcase
      if (func_r inside {FN_FIND, FN_CREATE}) begin
        out_bucket_r <= 10'(bucket);
      end else begin
        out_bucket_r <= 10'd0;
      end
    end
  end

  assign out_status        = out_status_r;
  assign out_result_handle = out_handle_r;
  assign out_bucket_index  = out_bucket_r;

  // Status to the controller
  always_comb begin
    sts.func       = func_r;
    sts.hash_last  = (cnt_r == CW'(4));
    sts.bkt_last   = (cnt_r == CW'(BUCKETS - 1));
    sts.ent_last   = (cnt_r == CW'(ENTRIES - 1));
    sts.cur_valid  = cur_r[LW-1];
    sts.prev_valid = prev_valid_r;
    sts.key_hit    = (key_q == key_r);
    sts.id_hit     = ({key_q[87:80], key_q[95:88]} == key_r[95:80]) &&
                     ({key_q[7:0], key_q[15:8]} == key_r[15:0]);
    sts.cur_is_hdl = (cur_r[IW-1:0] == hsl);
    sts.hdl_ok     = (32'(handle_r) < 32'(ENTRIES)) && live_r[hsl];
    sts.cnt_live   = live_r[cnt_slot];
  end

endmodule

### hdl/skht_ctrl.sv
// Controller: sequences hashing, chain walks, scans and clearing; owns the handshakes.
module skht_ctrl import skht_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  skht_sts_t sts,
  output skht_cmd_t cmd
);

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_DISP = 5'd2;
  localparam logic [4:0] S_HASH = 5'd3;
  localparam logic [4:0] S_HRD  = 5'd5;
  localparam logic [4:0] S_HWT  = 5'd6;
  localparam logic [4:0] S_FREE = 5'd7;
  localparam logic [4:0] S_CWR  = 5'd8;
  localparam logic [4:0] S_DCHK = 5'd9;
  localparam logic [4:0] S_DKEY = 5'd10;
  localparam logic [4:0] S_SRD  = 5'd11;
  localparam logic [4:0] S_SWT  = 5'd12;
  localparam logic [4:0] S_WALK = 5'd13;
  localparam logic [4:0] S_WCHK = 5'd14;
  localparam logic [4:0] S_RESP = 5'd15;

  logic [4:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       clr_resp_r, clr_resp_nxt;
  logic [1:0] rstat_r, rstat_nxt;
  logic [1:0] rsel_r, rsel_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and datapath commands
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    clr_resp_nxt  = clr_resp_r;
    rstat_nxt     = rstat_r;
    rsel_nxt      = rsel_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_CLR: begin
        cmd.head_wr = HW_CLR;
        cmd.cnt_inc = 1'b1;
        if (sts.bkt_last) begin
          cmd.cnt_clr = 1'b1;
          if (clr_resp_r) begin
            rstat_nxt = ST_OK;
            rsel_nxt  = RS_NONE;
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load     = 1'b1;
          cmd.cnt_clr  = 1'b1;
          cmd.hash_clr = 1'b1;
          state_nxt    = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.func)
          FN_FIND, FN_CREATE: state_nxt = S_HASH;
          FN_DELETE:          state_nxt = S_DCHK;
          FN_FIND_IDS:        state_nxt = S_SRD;
          FN_CLEAR: begin
            cmd.live_clr_all = 1'b1;
            clr_resp_nxt     = 1'b1;
            state_nxt        = S_CLR;
          end
          default: begin
            rstat_nxt = ST_NOT_FOUND;
            rsel_nxt  = RS_NONE;
            state_nxt = S_RESP;
          end
        endcase
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        cmd.cnt_inc   = 1'b1;
        if (sts.hash_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_HRD;
        end
      end
      S_HRD: begin
        cmd.head_rd = 1'b1;
        state_nxt   = S_HWT;
      end
      S_HWT: begin
        cmd.cur_ld_head = 1'b1;
        cmd.prev_clr    = 1'b1;
        state_nxt       = (sts.func == FN_CREATE) ? S_FREE : S_WALK;
      end
      S_FREE: begin
        // Find the lowest free slot
        if (!sts.cnt_live) begin
          state_nxt = S_CWR;
        end else if (sts.ent_last) begin
          rstat_nxt = ST_FULL;
          rsel_nxt  = RS_NONE;
          state_nxt = S_RESP;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_CWR: begin
        // Push the new slot at the head of its bucket
        cmd.slot_wr_new = 1'b1;
        cmd.head_wr     = HW_NEW;
        rstat_nxt       = ST_OK;
        rsel_nxt        = RS_CNT;
        state_nxt       = S_RESP;
      end
      S_DCHK: begin
        if (!sts.hdl_ok) begin
          rstat_nxt = ST_NOT_FOUND;
          rsel_nxt  = RS_NONE;
          state_nxt = S_RESP;
        end else begin
          cmd.slot_rd     = 1'b1;
          cmd.slot_rd_hdl = 1'b1;
          state_nxt       = S_DKEY;
        end
      end
      S_DKEY: begin
        // Rehash the stored key to find the chain
        cmd.key_from_slot = 1'b1;
        cmd.hash_clr      = 1'b1;
        cmd.cnt_clr       = 1'b1;
        state_nxt         = S_HASH;
      end
      S_SRD: begin
        cmd.head_rd      = 1'b1;
        cmd.head_rd_scan = 1'b1;
        state_nxt        = S_SWT;
      end
      S_SWT: begin
        cmd.cur_ld_head = 1'b1;
        cmd.prev_clr    = 1'b1;
        state_nxt       = S_WALK;
      end
      S_WALK: begin
        if (sts.cur_valid) begin
          cmd.slot_rd = 1'b1;
          state_nxt   = S_WCHK;
        end else begin
          // End of chain
          rsel_nxt = RS_NONE;
          case (sts.func)
            FN_DELETE: begin
              cmd.live_free = 1'b1;
              rstat_nxt     = ST_OK;
              state_nxt     = S_RESP;
            end
            FN_FIND_IDS: begin
              if (sts.bkt_last) begin
                rstat_nxt = ST_NOT_FOUND;
                state_nxt = S_RESP;
              end else begin
                cmd.cnt_inc = 1'b1;
                state_nxt   = S_SRD;
              end
            end
            default: begin
              rstat_nxt = ST_NOT_FOUND;
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_WCHK: begin
        case (sts.func)
          FN_DELETE: begin
            if (sts.cur_is_hdl) begin
              // Unlink the slot from its predecessor or the head
              if (sts.prev_valid) begin
                cmd.next_wr_prev = 1'b1;
              end else begin
                cmd.head_wr = HW_NEXT;
              end
              cmd.live_free = 1'b1;
              rstat_nxt     = ST_OK;
              rsel_nxt      = RS_NONE;
              state_nxt     = S_RESP;
            end else begin
              cmd.cur_ld_next = 1'b1;
              state_nxt       = S_WALK;
            end
          end
          FN_FIND_IDS: begin
            if (sts.id_hit) begin
              rstat_nxt = ST_OK;
              rsel_nxt  = RS_CUR;
              state_nxt = S_RESP;
            end else begin
              cmd.cur_ld_next = 1'b1;
              state_nxt       = S_WALK;
            end
          end
          default: begin
            if (sts.key_hit) begin
              rstat_nxt = ST_OK;
              rsel_nxt  = RS_CUR;
              state_nxt = S_RESP;
            end else begin
              cmd.cur_ld_next = 1'b1;
              state_nxt       = S_WALK;
            end
          end
        endcase
      end
      S_RESP: begin
        // Hold until the result register is free
        if (!out_valid_r || !out_stall) begin
          cmd.resp_ld     = 1'b1;
          cmd.resp_status = rstat_r;
          cmd.res_sel     = rsel_r;
          out_valid_nxt   = 1'b1;
          clr_resp_nxt    = 1'b0;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
      clr_resp_r  <= 1'b0;
      rstat_r     <= ST_OK;
      rsel_r      <= RS_NONE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clr_resp_r  <= clr_resp_nxt;
      rstat_r     <= rstat_nxt;
      rsel_r      <= rsel_nxt;
    end
  end

endmodule

### hdl/session_key_hash_table_top.sv
// Top level of the chained session key hash table.
// One request at a time. Find and create hash the key field by field and take the bucket as the
// low hash bits (BUCKETS is a power of two), then walk the bucket chain, reading each entry
// from the slot memories and then comparing it; a create also scans the live bits for the
// lowest free slot, one slot per cycle. Delete reads the slot's key, rehashes it and walks
// its chain. Find by ids reads each bucket head in turn and walks its chain until a match.
// Clear sweeps the bucket head memory and clears the live bits, and the same clearing pass
// runs after reset, with the input stalled.
// A further request is taken while the last result still waits on the output.
module session_key_hash_table_top import skht_pkg::*; #(
  parameter int BUCKETS = 1024,
  parameter int ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_dest_address,
  input  logic [15:0] in_tunnel_number,
  input  logic [31:0] in_ext_tunnel_address,
  input  logic [31:0] in_sender_address,
  input  logic [15:0] in_path_instance,
  input  logic [7:0]  in_entry_handle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_result_handle,
  output logic [9:0]  out_bucket_index
);

  skht_cmd_t cmd;
  skht_sts_t sts;

  skht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  skht_dp #(
    .BUCKETS (BUCKETS),
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_func               (in_func),
    .in_dest_address       (in_dest_address),
    .in_tunnel_number      (in_tunnel_number),
    .in_ext_tunnel_address (in_ext_tunnel_address),
    .in_sender_address     (in_sender_address),
    .in_path_instance      (in_path_instance),
    .in_entry_handle       (in_entry_handle),
    .cmd                   (cmd),
    .sts                   (sts),
    .out_status            (out_status),
    .out_result_handle     (out_result_handle),
    .out_bucket_index      (out_bucket_index)
  );

endmodule

### tb/sv/session_key_hash_table_checker.sv
// Checker for the session key hash table: predicts every request and compares results.
`timescale 1ns / 1ps
module session_key_hash_table_checker import skht_pkg::*; #(
  parameter int BUCKETS = 1024,
  parameter int ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_dest_address,
  input  logic [15:0] in_tunnel_number,
  input  logic [31:0] in_ext_tunnel_address,
  input  logic [31:0] in_sender_address,
  input  logic [15:0] in_path_instance,
  input  logic [7:0]  in_entry_handle,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [7:0]  out_result_handle,
  input  logic [9:0]  out_bucket_index,
  output int          errors,
  output int          received,
  output int          full_seen,
  output int          hits_seen
);

  typedef struct packed {
    logic [31:0] dest;
    logic [15:0] tun;
    logic [31:0] ext;
    logic [31:0] snd;
    logic [15:0] inst;
  } sess_key_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] handle;
    logic [9:0] bucket;
  } lookup_res_t;

  // Shadow copy of the table
  logic      head_vld [BUCKETS];
  int        head_idx [BUCKETS];
  sess_key_t slot_key [ENTRIES];
  logic      next_vld [ENTRIES];
  int        next_idx [ENTRIES];
  logic      slot_busy [ENTRIES];

  lookup_res_t pending_results [$];

  initial begin
    errors = 0;
    full_seen = 0;
    hits_seen = 0;
    for (int b = 0; b < BUCKETS; b++) begin
      head_vld[b] = 1'b0;
      head_idx[b] = 0;
    end
    for (int s = 0; s < ENTRIES; s++) begin
      slot_busy[s] = 1'b0;
      next_vld[s] = 1'b0;
      next_idx[s] = 0;
    end
  end

  function automatic int bucket_of(sess_key_t k);
    logic [31:0] h;
    h = k.dest;
    h = h * 32'd31 + {16'd0, k.tun};
    h = h * 32'd31 + k.ext;
    h = h * 32'd31 + k.snd;
    h = h * 32'd31 + {16'd0, k.inst};
    return int'(h % BUCKETS);
  endfunction

  function automatic logic [15:0] swap_bytes(logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  // Work out the result of one request and update the shadow table
  task automatic predict_request(logic [2:0] fn, sess_key_t k, logic [7:0] hdl);
    lookup_res_t r;
    int cur, prev, b, steps;
    logic cur_v, have_prev, hit;
    r = '{status: ST_NOT_FOUND, handle: '0, bucket: '0};
    case (fn)
      FN_FIND: begin
        b = bucket_of(k);
        r.bucket = b[9:0];
        cur_v = head_vld[b];
        cur = head_idx[b];
        for (steps = 0; cur_v && steps < ENTRIES; steps++) begin
          if (slot_key[cur] == k) begin
            r.status = ST_OK;
            r.handle = cur[7:0];
            break;
          end
          cur_v = next_vld[cur];
          cur = next_idx[cur];
        end
      end
      FN_CREATE: begin
        b = bucket_of(k);
        r.bucket = b[9:0];
        r.status = ST_FULL;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!slot_busy[i]) begin
            slot_key[i] = k;
            next_vld[i] = head_vld[b];
            next_idx[i] = head_idx[b];
            head_vld[b] = 1'b1;
            head_idx[b] = i;
            slot_busy[i] = 1'b1;
            r.status = ST_OK;
            r.handle = i[7:0];
            break;
          end
        end
      end
      FN_DELETE: begin
        if (int'(hdl) < ENTRIES && slot_busy[hdl]) begin
          b = bucket_of(slot_key[hdl]);
          have_prev = 1'b0;
          prev = 0;
          cur_v = head_vld[b];
          cur = head_idx[b];
          for (steps = 0; cur_v && steps < ENTRIES; steps++) begin
            if (cur == int'(hdl)) begin
              if (have_prev) begin
                next_vld[prev] = next_vld[cur];
                next_idx[prev] = next_idx[cur];
              end else begin
                head_vld[b] = next_vld[cur];
                head_idx[b] = next_idx[cur];
              end
              break;
            end
            have_prev = 1'b1;
            prev = cur;
            cur_v = next_vld[cur];
            cur = next_idx[cur];
          end
          slot_busy[hdl] = 1'b0;
          r.status = ST_OK;
        end
      end
      FN_FIND_IDS: begin
        hit = 1'b0;
        for (int i = 0; i < BUCKETS && !hit; i++) begin
          cur_v = head_vld[i];
          cur = head_idx[i];
          for (steps = 0; cur_v && steps < ENTRIES; steps++) begin
            if (swap_bytes(slot_key[cur].tun) == k.tun &&
                swap_bytes(slot_key[cur].inst) == k.inst) begin
              hit = 1'b1;
              r.status = ST_OK;
              r.handle = cur[7:0];
              break;
            end
            cur_v = next_vld[cur];
            cur = next_idx[cur];
          end
        end
      end
      FN_CLEAR: begin
        for (int i = 0; i < BUCKETS; i++) head_vld[i] = 1'b0;
        for (int i = 0; i < ENTRIES; i++) slot_busy[i] = 1'b0;
        r.status = ST_OK;
      end
      default: ;
    endcase
    pending_results.push_back(r);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH result %0d %s: got %0d expected %0d", received, what, got, want);
    errors++;
  endtask

  // Predict on each accepted request, then compare each accepted result
  always @(posedge clk) begin
    lookup_res_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        predict_request(in_func, {in_dest_address, in_tunnel_number, in_ext_tunnel_address,
                                  in_sender_address, in_path_instance}, in_entry_handle);
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, status", out_status, -1);
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_result_handle !== want.handle)
            report_mismatch("handle", out_result_handle, want.handle);
          if (out_bucket_index !== want.bucket)
            report_mismatch("bucket", out_bucket_index, want.bucket);
          if (want.status == ST_FULL) full_seen++;
          if (want.status == ST_OK && want.handle != 0) hits_seen++;
        end
        received <= received + 1;
      end
    end else begin
      received <= 0;
    end
  end

endmodule

### tb/sv/session_key_hash_table_top_tb.sv
// Testbench top: drives requests into the session key hash table and gives the verdict.
`timescale 1ns / 1ps
module session_key_hash_table_top_tb;
  import skht_pkg::*;

  localparam logic [2:0] FN_RSVD_FIRST = 3'd5;
  localparam logic [2:0] FN_RSVD_LAST  = 3'd7;
  localparam int POOL = 48;
  localparam int RANDOM_ITEMS = 1330;

  typedef struct packed {
    logic [31:0] dest;
    logic [15:0] tun;
    logic [31:0] ext;
    logic [31:0] snd;
    logic [15:0] inst;
  } sess_key_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_func = '0;
  logic [31:0] in_dest_address = '0;
  logic [15:0] in_tunnel_number = '0;
  logic [31:0] in_ext_tunnel_address = '0;
  logic [31:0] in_sender_address = '0;
  logic [15:0] in_path_instance = '0;
  logic [7:0]  in_entry_handle = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_result_handle;
  logic [9:0]  out_bucket_index;

  int errors, received, full_seen, hits_seen;
  int sent = 0;
  int op_count [8];
  int hold_left = 0;
  logic hold_done = 1'b0;
  logic no_idle = 1'b0;
  sess_key_t key_pool [POOL];

  session_key_hash_table_top dut (.*);

  session_key_hash_table_checker checker_i (
    .clk, .rst_n, .in_valid, .in_stall, .in_func, .in_dest_address, .in_tunnel_number,
    .in_ext_tunnel_address, .in_sender_address, .in_path_instance, .in_entry_handle,
    .out_valid, .out_stall, .out_status, .out_result_handle, .out_bucket_index,
    .errors, .received, .full_seen, .hits_seen
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side at random, with one long hold-off and one clean stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && received >= 300) begin
      out_stall <= 1'b1;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (received >= 700 && received < 900) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 16);
    end
  end

  // Offer one request and hold it until accepted, then maybe idle
  task automatic send_request(logic [2:0] fn, sess_key_t k, logic [7:0] hdl);
    in_valid <= 1'b1;
    in_func <= fn;
    {in_dest_address, in_tunnel_number, in_ext_tunnel_address, in_sender_address,
     in_path_instance} <= k;
    in_entry_handle <= hdl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    op_count[fn]++;
    if (!no_idle && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sent != received) @(posedge clk);
  endtask

  function automatic sess_key_t random_key();
    return {$urandom(), 16'($urandom()), $urandom(), $urandom(), 16'($urandom())};
  endfunction

  function automatic sess_key_t ids_of(sess_key_t k);
    sess_key_t q;
    q = random_key();
    q.tun = {k.tun[7:0], k.tun[15:8]};
    q.inst = {k.inst[7:0], k.inst[15:8]};
    return q;
  endfunction

  initial begin
    sess_key_t k, ones, zeros;
    logic [2:0] fn;
    int pick, drain_cycles;
    for (int i = 0; i < 8; i++) op_count[i] = 0;
    // Groups of four keys that land in one bucket, for chain walks and unlinks
    for (int g = 0; g < POOL / 4; g++) begin
      k = random_key();
      for (int j = 0; j < 4; j++) begin
        key_pool[g * 4 + j] = k;
        key_pool[g * 4 + j].inst = k.inst + 16'(j * 1024);
      end
    end
    ones = '1;
    zeros = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty finds, extremes, duplicates, a head unlink, id search, clear
    send_request(FN_FIND, ones, 8'd0);
    send_request(FN_FIND_IDS, zeros, 8'd0);
    send_request(FN_CREATE, zeros, 8'd0);
    send_request(FN_CREATE, ones, 8'd0);
    send_request(FN_FIND, ones, 8'd0);
    send_request(FN_FIND, zeros, 8'd0);
    send_request(FN_CREATE, key_pool[0], 8'd0);
    send_request(FN_CREATE, key_pool[0], 8'd0);
    send_request(FN_FIND, key_pool[0], 8'd0);
    send_request(FN_CREATE, key_pool[1], 8'd0);
    send_request(FN_CREATE, key_pool[2], 8'd0);
    send_request(FN_DELETE, zeros, 8'd5);
    send_request(FN_FIND, key_pool[1], 8'd0);
    send_request(FN_DELETE, zeros, 8'd6);
    send_request(FN_DELETE, zeros, 8'd6);
    send_request(FN_DELETE, zeros, 8'hFF);
    send_request(FN_FIND_IDS, ids_of(key_pool[0]), 8'd0);
    send_request(FN_FIND_IDS, ids_of(ones), 8'd0);
    for (logic [3:0] f = FN_RSVD_FIRST; f <= FN_RSVD_LAST; f++)
      send_request(f[2:0], ones, 8'hFF);
    send_request(FN_CLEAR, zeros, 8'd0);
    send_request(FN_FIND, key_pool[0], 8'd0);
    send_request(FN_CREATE, key_pool[3], 8'd0);

    // Random: mostly pool keys, a fill stretch to reach full, some noise
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 700 && n < 900);
      if (n == 950) wait_drain();
      k = ($urandom_range(0, 99) < 80) ? key_pool[$urandom_range(0, POOL - 1)] : random_key();
      pick = $urandom_range(0, 99);
      if (n >= 300 && n < 600)
        fn = (pick < 92) ? FN_CREATE : FN_FIND;
      else if (pick < 35) fn = FN_CREATE;
      else if (pick < 60) fn = FN_FIND;
      else if (pick < 85) fn = FN_DELETE;
      else if (pick < 91) fn = FN_FIND_IDS;
      else if (pick < 92) fn = FN_CLEAR;
      else if (pick < 95) fn = 3'($urandom_range(FN_RSVD_FIRST, FN_RSVD_LAST));
      else fn = 3'($urandom());
      if (fn == FN_FIND_IDS && $urandom_range(0, 99) < 60) k = ids_of(k);
      send_request(fn, k, 8'($urandom()));
    end

    // Wait for the last results, bounded, then let the block settle
    in_valid <= 1'b0;
    drain_cycles = 0;
    while (sent != received && drain_cycles < 200000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (50) @(posedge clk);

    $display("Sent %0d requests: %0d finds, %0d creates, %0d deletes, %0d id searches,",
             sent, op_count[FN_FIND], op_count[FN_CREATE], op_count[FN_DELETE],
             op_count[FN_FIND_IDS]);
    $display("%0d clears, %0d unused codes; %0d table-full and %0d nonzero-handle results.",
             op_count[FN_CLEAR], op_count[5] + op_count[6] + op_count[7],
             full_seen, hits_seen);
    if (errors == 0 && sent == received) begin
      $display("TEST PASSED");
    end else begin
      if (sent != received) $display("%0d results never arrived", sent - received);
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard stop for a hung run
  initial begin
    #200_000_000;
    $display("Timeout after %0d requests and %0d results", sent, received);
    $display("TEST FAILED");
    $finish;
  end

endmodule
